[rtl/core/pinch_gesture_qualifier_assert.svh]
// Assertion macros used by the pinch qualifier back end (pgq_back).
// Every assertion is sampled on clk_i and is off while rst_ni is low.
`ifndef PINCH_GESTURE_QUALIFIER_ASSERT_SVH
`define PINCH_GESTURE_QUALIFIER_ASSERT_SVH

// Same-cycle implication.
`define PGQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pinch qualifier assertion failed");

// Next-cycle implication.
`define PGQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pinch qualifier assertion failed");

`endif

[rtl/core/pgq_pkg.sv]
package pgq_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DistW  = 34;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_CLOSE_DIST = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OPEN_DIST  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CONFIRM    = 2'd2;

  localparam logic [DistW-1:0]  CLOSE_DIST_RST = 34'd40000;
  localparam logic [DistW-1:0]  OPEN_DIST_RST  = 34'd160000;
  localparam logic [CountW-1:0] CONFIRM_RST    = 8'd3;

  typedef struct packed {
    logic [DistW-1:0]  close_distance_sq;
    logic [DistW-1:0]  open_distance_sq;
    logic [CountW-1:0] confirm_frames;
  } pgq_cfg_t;

  // One classified frame travelling from the front end to the back end.
  typedef struct packed {
    logic                     tracking;
    logic [DistW-1:0]         distance_sq;
    logic signed [CoordW-1:0] mid_x;
    logic signed [CoordW-1:0] mid_y;
    logic signed [CoordW-1:0] mid_z;
  } pgq_item_t;

endpackage

[rtl/core/pgq_if.sv]
interface pgq_in_if;
  logic               valid;
  logic               ready;
  logic               hand_tracked;
  logic               thumb_tracked;
  logic               index_tracked;
  logic signed [15:0] thumb_x;
  logic signed [15:0] thumb_y;
  logic signed [15:0] thumb_z;
  logic signed [15:0] index_x;
  logic signed [15:0] index_y;
  logic signed [15:0] index_z;

  modport source (
    output valid, hand_tracked, thumb_tracked, index_tracked,
           thumb_x, thumb_y, thumb_z, index_x, index_y, index_z,
    input  ready
  );
  modport sink (
    input  valid, hand_tracked, thumb_tracked, index_tracked,
           thumb_x, thumb_y, thumb_z, index_x, index_y, index_z,
    output ready
  );
endinterface

interface pgq_out_if;
  logic               valid;
  logic               ready;
  logic               tracking;
  logic               pinched;
  logic               began;
  logic               released;
  logic [33:0]        distance_sq;
  logic signed [15:0] pinch_x;
  logic signed [15:0] pinch_y;
  logic signed [15:0] pinch_z;

  modport source (
    output valid, tracking, pinched, began, released,
           distance_sq, pinch_x, pinch_y, pinch_z,
    input  ready
  );
  modport sink (
    input  valid, tracking, pinched, began, released,
           distance_sq, pinch_x, pinch_y, pinch_z,
    output ready
  );
endinterface

[rtl/core/pgq_front.sv]
module pgq_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  pgq_in_if.sink              in_if,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output pgq_pkg::pgq_item_t  push_item_o
);
  import pgq_pkg::*;

  localparam int unsigned NumAxes = 3;
  localparam int unsigned SqW = 2 * CoordW;

  logic signed [CoordW-1:0] thumb [NumAxes];
  logic signed [CoordW-1:0] index [NumAxes];
  logic [CoordW-1:0]        adiff [NumAxes];
  logic signed [CoordW-1:0] mid   [NumAxes];

  logic                     s1_valid_q;
  logic                     s1_trk_q;
  logic [CoordW-1:0]        s1_adiff_q [NumAxes];
  logic signed [CoordW-1:0] s1_mid_q   [NumAxes];

  logic                     s2_valid_q;
  logic                     s2_trk_q;
  logic [SqW-1:0]           s2_sq_q    [NumAxes];
  logic signed [CoordW-1:0] s2_mid_q   [NumAxes];

  logic s1_adv;
  logic s2_adv;

  assign thumb[0] = in_if.thumb_x;
  assign thumb[1] = in_if.thumb_y;
  assign thumb[2] = in_if.thumb_z;
  assign index[0] = in_if.index_x;
  assign index[1] = in_if.index_y;
  assign index[2] = in_if.index_z;

  // Per-axis absolute difference and floor midpoint, both exact in 17 bits.
  for (genvar a = 0; a < NumAxes; a++) begin : g_axis
    logic signed [CoordW:0] diff;
    logic signed [CoordW:0] sum;
    logic [CoordW:0]        mag;
    assign diff     = {thumb[a][CoordW-1], thumb[a]} - {index[a][CoordW-1], index[a]};
    assign sum      = {thumb[a][CoordW-1], thumb[a]} + {index[a][CoordW-1], index[a]};
    assign mag      = diff[CoordW] ? (CoordW+1)'(-diff) : (CoordW+1)'(diff);
    assign adiff[a] = mag[CoordW-1:0];
    assign mid[a]   = sum[CoordW:1];
  end

  assign s2_adv      = !s2_valid_q || push_ready_i;
  assign s1_adv      = !s1_valid_q || s2_adv;
  assign in_if.ready = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_if.valid;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_trk_q <= in_if.hand_tracked & in_if.thumb_tracked & in_if.index_tracked;
      for (int a = 0; a < NumAxes; a++) begin
        s1_adiff_q[a] <= adiff[a];
        s1_mid_q[a]   <= mid[a];
      end
    end
    if (s2_adv) begin
      s2_trk_q <= s1_trk_q;
      for (int a = 0; a < NumAxes; a++) begin
        s2_sq_q[a]  <= s1_adiff_q[a] * s1_adiff_q[a];
        s2_mid_q[a] <= s1_mid_q[a];
      end
    end
  end

  assign push_valid_o             = s2_valid_q;
  assign push_item_o.tracking     = s2_trk_q;
  assign push_item_o.distance_sq  = DistW'(s2_sq_q[0]) + DistW'(s2_sq_q[1])
                                  + DistW'(s2_sq_q[2]);
  assign push_item_o.mid_x        = s2_mid_q[0];
  assign push_item_o.mid_y        = s2_mid_q[1];
  assign push_item_o.mid_z        = s2_mid_q[2];

endmodule

[rtl/core/pgq_fifo.sv]
module pgq_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  pgq_pkg::pgq_item_t  push_item_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output pgq_pkg::pgq_item_t  pop_item_o
);
  import pgq_pkg::*;

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  pgq_item_t         mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != CountW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[rtl/core/pgq_back.sv]
`include "pinch_gesture_qualifier_assert.svh"

module pgq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pgq_pkg::pgq_cfg_t   cfg_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  pgq_pkg::pgq_item_t  pop_item_i,
  pgq_out_if.source           out_if
);
  import pgq_pkg::*;

  typedef enum logic {
    ST_OPEN,
    ST_PINCHED
  } pinch_e;

  pinch_e            state_q;
  logic [CountW-1:0] count_q;
  logic              out_valid_q;
  logic              trk_q, began_q, released_q;
  logic [DistW-1:0]  dist_q;
  logic signed [CoordW-1:0] mid_x_q, mid_y_q, mid_z_q;

  logic            adv, take;
  logic            qualifies, switch_st;
  logic [CountW:0] count_inc;

  assign adv         = !out_valid_q || out_if.ready;
  assign pop_ready_o = adv;
  assign take        = pop_valid_i && adv;

  assign qualifies = (state_q == ST_PINCHED)
                   ? (pop_item_i.distance_sq > cfg_i.open_distance_sq)
                   : (pop_item_i.distance_sq < cfg_i.close_distance_sq);
  assign count_inc = {1'b0, count_q} + 1'b1;
  // A confirm count of zero behaves like one: the first qualifying frame switches.
  assign switch_st = qualifies && (count_inc >= {1'b0, cfg_i.confirm_frames});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_OPEN;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      trk_q       <= 1'b0;
      began_q     <= 1'b0;
      released_q  <= 1'b0;
      dist_q      <= '0;
      mid_x_q     <= '0;
      mid_y_q     <= '0;
      mid_z_q     <= '0;
    end else if (take) begin
      out_valid_q <= 1'b1;
      trk_q       <= pop_item_i.tracking;
      began_q     <= 1'b0;
      released_q  <= 1'b0;
      if (!pop_item_i.tracking) begin
        count_q <= '0;
      end else begin
        dist_q  <= pop_item_i.distance_sq;
        mid_x_q <= pop_item_i.mid_x;
        mid_y_q <= pop_item_i.mid_y;
        mid_z_q <= pop_item_i.mid_z;
        if (switch_st) begin
          count_q <= '0;
          case (state_q)
            ST_OPEN: begin
              state_q <= ST_PINCHED;
              began_q <= 1'b1;
            end
            ST_PINCHED: begin
              state_q    <= ST_OPEN;
              released_q <= 1'b1;
            end
            default: begin
              state_q <= ST_OPEN;
            end
          endcase
        end else if (qualifies) begin
          count_q <= count_inc[CountW-1:0];
        end else begin
          count_q <= '0;
        end
      end
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.tracking    = trk_q;
  assign out_if.pinched     = (state_q == ST_PINCHED);
  assign out_if.began       = began_q;
  assign out_if.released    = released_q;
  assign out_if.distance_sq = dist_q;
  assign out_if.pinch_x     = mid_x_q;
  assign out_if.pinch_y     = mid_y_q;
  assign out_if.pinch_z     = mid_z_q;

  `PGQ_ASSERT_IMP(a_pulse_excl, out_valid_q, !(began_q && released_q))
  `PGQ_ASSERT_IMP(a_began_pinched, out_valid_q && began_q, state_q == ST_PINCHED)
  `PGQ_ASSERT_IMP(a_count_max, 1'b1, count_q != {CountW{1'b1}})
  `PGQ_ASSERT_NXT(a_untracked_clear, take && !pop_item_i.tracking,
                  count_q == '0 && !began_q && !released_q)
  `PGQ_ASSERT_NXT(a_stall_holds_state, out_valid_q && !out_if.ready,
                  $stable(state_q) && $stable(count_q))

endmodule

[rtl/core/pinch_gesture_qualifier.sv]
// Pinch gesture qualifier.
// Frames come in on in_if, one per transaction: the three tracked flags and
// the thumb-tip and index-tip positions. Each frame gives exactly one result
// transaction on out_if with the tracking flag, the pinch state after the
// frame, the began and released pulses, the squared thumb-index distance and
// the midpoint of the two tips. While a frame is not fully tracked, the
// distance and midpoint repeat the last tracked values and the run counter
// clears.
// The result is registered: a frame passes the two front-end stages, the
// frame queue and the output register before out_if.valid rises for it.
// Throughput is one transaction per cycle while out_if.ready stays high, set
// by the combinational threshold compare and counter update in the back end.
// Reset clears the pinch state, the run counter, the held distance and
// midpoint, empties the pipeline and loads the threshold registers with their
// defaults. When the receiver stalls, the output register holds its result,
// the queue absorbs frames in flight, and then in_if.ready drops.
// The user must write thresholds through cfg_we_i/cfg_idx_i/cfg_data_i only while idle; the block does not enforce it.
module pinch_gesture_qualifier #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pgq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pgq_pkg::DistW-1:0]    cfg_data_i,
  pgq_in_if.sink                       in_if,
  pgq_out_if.source                    out_if
);
  import pgq_pkg::*;

  pgq_cfg_t  cfg_q;
  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  pgq_item_t push_item, pop_item;

  // Configuration registers; an index past the last register is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.close_distance_sq <= CLOSE_DIST_RST;
      cfg_q.open_distance_sq  <= OPEN_DIST_RST;
      cfg_q.confirm_frames    <= CONFIRM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLOSE_DIST: cfg_q.close_distance_sq <= cfg_data_i;
        CFG_OPEN_DIST:  cfg_q.open_distance_sq  <= cfg_data_i;
        CFG_CONFIRM:    cfg_q.confirm_frames    <= cfg_data_i[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front end computes distance and midpoint; the back end runs the
  // hysteresis. The queue lets the back end stall without losing frames.
  pgq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  pgq_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  pgq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_if      (out_if)
  );

endmodule

[tb/pinch_gesture_qualifier_checker.sv]
module pinch_gesture_qualifier_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pgq_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pgq_pkg::DistW-1:0]   cfg_data_i,
  pgq_in_if                           in_ch,
  pgq_out_if                          out_ch,
  output int unsigned                 failures_o,
  output int unsigned                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pgq_pkg::*;

  typedef struct packed {
    logic                     tracking;
    logic                     pinched;
    logic                     began;
    logic                     released;
    logic [DistW-1:0]         distance_sq;
    logic signed [CoordW-1:0] pinch_x;
    logic signed [CoordW-1:0] pinch_y;
    logic signed [CoordW-1:0] pinch_z;
  } pinch_result_t;

  pinch_result_t expected_results_q[$];

  // Shadow of the threshold registers and of the qualifier state.
  logic [DistW-1:0]         close_thr   = CLOSE_DIST_RST;
  logic [DistW-1:0]         open_thr    = OPEN_DIST_RST;
  logic [CountW-1:0]        confirm_cnt = CONFIRM_RST;
  logic                     pinched_q   = 1'b0;
  logic [CountW-1:0]        run_count   = '0;
  logic [DistW-1:0]         held_dist   = '0;
  logic signed [CoordW-1:0] held_x      = '0;
  logic signed [CoordW-1:0] held_y      = '0;
  logic signed [CoordW-1:0] held_z      = '0;
  int unsigned              mismatches  = 0;

  function automatic logic [DistW-1:0] axis_sq(logic signed [CoordW-1:0] a,
                                               logic signed [CoordW-1:0] b);
    logic signed [CoordW:0] d;
    logic [DistW-1:0]       m;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    m = (d < 0) ? DistW'(-d) : DistW'(d);
    return m * m;
  endfunction

  // Floor of the half sum: a 17-bit sum shifted right by one.
  function automatic logic signed [CoordW-1:0] half_sum(logic signed [CoordW-1:0] a,
                                                        logic signed [CoordW-1:0] b);
    logic [CoordW:0] s;
    s = {a[CoordW-1], a} + {b[CoordW-1], b};
    return s[CoordW:1];
  endfunction

  function automatic pinch_result_t predict_frame();
    pinch_result_t r;
    logic [CountW:0] next_count;
    logic            qualifies;
    r = '0;
    r.tracking = in_ch.hand_tracked & in_ch.thumb_tracked & in_ch.index_tracked;
    if (!r.tracking) begin
      run_count = '0;
    end else begin
      held_dist = axis_sq(in_ch.thumb_x, in_ch.index_x) + axis_sq(in_ch.thumb_y, in_ch.index_y)
                + axis_sq(in_ch.thumb_z, in_ch.index_z);
      held_x = half_sum(in_ch.thumb_x, in_ch.index_x);
      held_y = half_sum(in_ch.thumb_y, in_ch.index_y);
      held_z = half_sum(in_ch.thumb_z, in_ch.index_z);
      qualifies = pinched_q ? (held_dist > open_thr) : (held_dist < close_thr);
      if (qualifies) begin
        next_count = {1'b0, run_count} + 1'b1;
        if (next_count >= {1'b0, confirm_cnt}) begin
          r.began    = !pinched_q;
          r.released = pinched_q;
          pinched_q  = !pinched_q;
          run_count  = '0;
        end else begin
          run_count = next_count[CountW-1:0];
        end
      end else begin
        run_count = '0;
      end
    end
    r.pinched     = pinched_q;
    r.distance_sq = held_dist;
    r.pinch_x     = held_x;
    r.pinch_y     = held_y;
    r.pinch_z     = held_z;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pinch_result_t want;
    if (!rst_ni) begin
      expected_results_q.delete();
      close_thr   = CLOSE_DIST_RST;
      open_thr    = OPEN_DIST_RST;
      confirm_cnt = CONFIRM_RST;
      pinched_q   = 1'b0;
      run_count   = '0;
      held_dist   = '0;
      held_x      = '0;
      held_y      = '0;
      held_z      = '0;
      pending_o  <= 0;
      failures_o <= mismatches;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results_q.size() == 0) begin
          $error("pinch result transaction with no frame waiting");
          mismatches++;
        end else begin
          want = expected_results_q.pop_front();
          check_field("tracking", want.tracking, out_ch.tracking);
          check_field("pinched", want.pinched, out_ch.pinched);
          check_field("began", want.began, out_ch.began);
          check_field("released", want.released, out_ch.released);
          check_field("distance_sq", want.distance_sq, out_ch.distance_sq);
          check_field("pinch_x", want.pinch_x, out_ch.pinch_x);
          check_field("pinch_y", want.pinch_y, out_ch.pinch_y);
          check_field("pinch_z", want.pinch_z, out_ch.pinch_z);
        end
      end
      if (in_ch.valid && in_ch.ready) expected_results_q.push_back(predict_frame());
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CLOSE_DIST: close_thr   = cfg_data_i;
          CFG_OPEN_DIST:  open_thr    = cfg_data_i;
          CFG_CONFIRM:    confirm_cnt = cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      pending_o  <= expected_results_q.size();
      failures_o <= mismatches;
    end
  end

endmodule

[tb/pinch_gesture_qualifier_test.sv]
// Stimulus and verdict for the pinch gesture qualifier. The checker instance
// beside the block predicts every result transaction and counts mismatches;
// this module only produces frames, threshold writes and back-pressure.
module pinch_gesture_qualifier_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pgq_pkg::*;

  // The register index space has one slot with no register behind it.
  localparam logic [CfgIdxW-1:0] CFG_SPARE  = 2'd3;
  localparam logic [DistW-1:0]   DIST_TOP   = 34'd12884115468;
  localparam int unsigned        CycleLimit = 400000;
  localparam int unsigned        PhaseItems = 100;
  localparam int unsigned        MaxMag     = 65535;

  typedef struct {
    logic                     hand;
    logic                     thumb;
    logic                     index;
    logic signed [CoordW-1:0] tx, ty, tz;
    logic signed [CoordW-1:0] ix, iy, iz;
  } pinch_frame_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DistW-1:0]   cfg_data_i;
  int unsigned        failures;
  int unsigned        pending;
  int unsigned        cycles = 0;
  int unsigned        frames_sent = 0;

  // Stimulus-side copy of the thresholds, used to aim frames at both sides
  // of each threshold.
  logic [DistW-1:0]   close_thr   = CLOSE_DIST_RST;
  logic [DistW-1:0]   open_thr    = OPEN_DIST_RST;
  logic [CountW-1:0]  confirm_lvl = CONFIRM_RST;

  // While a quiet flag is set, that side runs without idle cycles.
  bit                 quiet_src  = 1'b0;
  bit                 quiet_sink = 1'b0;

  pgq_in_if  in_ch ();
  pgq_out_if out_ch ();

  pinch_gesture_qualifier dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  pinch_gesture_qualifier_checker scoreboard (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .failures_o (failures),
    .pending_o  (pending)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("pinch_gesture_qualifier_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame builders.
  // ---------------------------------------------------------------------------

  function automatic pinch_frame_t frame_of(logic [2:0] flags, int tx, int ty, int tz,
                                            int ix, int iy, int iz);
    pinch_frame_t f;
    {f.hand, f.thumb, f.index} = flags;
    f.tx = CoordW'(tx);
    f.ty = CoordW'(ty);
    f.tz = CoordW'(tz);
    f.ix = CoordW'(ix);
    f.iy = CoordW'(iy);
    f.iz = CoordW'(iz);
    return f;
  endfunction

  // Full-range coordinates, so every coordinate bit toggles.
  function automatic pinch_frame_t noise_frame(logic [2:0] flags);
    return frame_of(flags, $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom());
  endfunction

  // Places the two tips of one axis exactly mag apart, anywhere in range.
  function automatic void place_axis(input int unsigned mag,
                                     output logic signed [CoordW-1:0] t,
                                     output logic signed [CoordW-1:0] i);
    int lo;
    lo = int'($urandom_range(0, MaxMag - mag)) - 32768;
    if ($urandom_range(0, 1) != 0) begin
      t = CoordW'(lo);
      i = CoordW'(lo + int'(mag));
    end else begin
      i = CoordW'(lo);
      t = CoordW'(lo + int'(mag));
    end
  endfunction

  function automatic pinch_frame_t spread_frame(int unsigned mx, int unsigned my,
                                                int unsigned mz);
    pinch_frame_t f;
    {f.hand, f.thumb, f.index} = 3'b111;
    place_axis(mx, f.tx, f.ix);
    place_axis(my, f.ty, f.iy);
    place_axis(mz, f.tz, f.iz);
    return f;
  endfunction

  // A frame strictly closer than the close threshold. With a zero threshold
  // nothing can qualify, so the tips just coincide.
  function automatic pinch_frame_t near_frame();
    longint b;
    b = 0;
    if (close_thr != 0) begin
      b = longint'($floor($sqrt(real'(close_thr - 1) / 3.0)));
      if (b > MaxMag) b = MaxMag;
      while (b > 0 && 3 * b * b >= longint'(close_thr)) b--;
    end
    return spread_frame($urandom_range(0, int'(b)), $urandom_range(0, int'(b)),
                        $urandom_range(0, int'(b)));
  endfunction

  // A frame strictly farther than the open threshold where the range allows.
  function automatic pinch_frame_t far_frame();
    longint m;
    m = longint'($ceil($sqrt(real'(open_thr) / 3.0)));
    while (m < MaxMag && 3 * m * m <= longint'(open_thr)) m++;
    m = m + $urandom_range(0, 3);
    if (m > MaxMag) m = MaxMag;
    return spread_frame(int'(m), int'(m), int'(m));
  endfunction

  // One axis set to land on, or just beside, one of the thresholds.
  function automatic pinch_frame_t edge_frame();
    longint r;
    int unsigned mags[3];
    r = longint'($floor($sqrt(real'(($urandom_range(0, 1) != 0) ? close_thr : open_thr))));
    r = r + $urandom_range(0, 2) - 1;
    if (r < 0) r = 0;
    if (r > MaxMag) r = MaxMag;
    mags = '{0, 0, 0};
    mags[$urandom_range(0, 2)] = int'(r);
    return spread_frame(mags[0], mags[1], mags[2]);
  endfunction

  // ---------------------------------------------------------------------------
  // Frame source. Each transaction may be preceded by idle cycles unless
  // the source is in a quiet stretch; valid is never dropped between
  // back-to-back frames.
  // ---------------------------------------------------------------------------

  task automatic send_frame(input pinch_frame_t f);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) quiet_src = !quiet_src;
    gap = quiet_src ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.hand_tracked  <= f.hand;
    in_ch.thumb_tracked <= f.thumb;
    in_ch.index_tracked <= f.index;
    in_ch.thumb_x       <= f.tx;
    in_ch.thumb_y       <= f.ty;
    in_ch.thumb_z       <= f.tz;
    in_ch.index_x       <= f.ix;
    in_ch.index_y       <= f.iy;
    in_ch.index_z       <= f.iz;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    frames_sent++;
  endtask

  // Stops the source and waits until every expected result has been seen.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Writes all three thresholds. With junk set, the confirm write carries
  // random bits above the 8-bit field and the unused index gets a write too;
  // both must be ignored by the block.
  task automatic program_thresholds(input logic [DistW-1:0] close_v,
                                    input logic [DistW-1:0] open_v,
                                    input logic [CountW-1:0] confirm_v, input bit junk);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CLOSE_DIST;
    cfg_data_i <= close_v;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_OPEN_DIST;
    cfg_data_i <= open_v;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CONFIRM;
    cfg_data_i <= junk ? {(DistW-CountW)'($urandom()), confirm_v} : DistW'(confirm_v);
    @(posedge clk_i);
    if (junk) begin
      cfg_idx_i  <= CFG_SPARE;
      cfg_data_i <= DistW'({$urandom(), $urandom()});
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b0;
    close_thr   = close_v;
    open_thr    = open_v;
    confirm_lvl = confirm_v;
  endtask

  // One gesture: mostly a closing run followed by an opening run, each about
  // as long as the confirm count so that both switching and falling just
  // short occur. A few frames inside a run are dropouts or threshold hits
  // that break it. The rest is noise and bare threshold probes.
  task automatic run_gesture();
    int unsigned roll;
    int unsigned len;
    int unsigned pick;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      for (int k = 0; k < 2; k++) begin
        len = ((confirm_lvl == 0) ? 1 : confirm_lvl) + $urandom_range(0, 3) - 1;
        repeat (len) begin
          pick = $urandom_range(0, 99);
          if (pick < 4) send_frame(noise_frame(3'($urandom_range(0, 6))));
          else if (pick < 8) send_frame(edge_frame());
          else if (k == 0) send_frame(near_frame());
          else send_frame(far_frame());
        end
      end
    end else if (roll < 90) begin
      repeat ($urandom_range(1, 4)) send_frame(noise_frame(3'($urandom())));
    end else begin
      repeat ($urandom_range(1, 3)) send_frame(edge_frame());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: ready may drop before each result unless the
  // sink is in a quiet stretch.
  // ---------------------------------------------------------------------------

  initial begin : sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) quiet_sink = !quiet_sink;
      stall = quiet_sink ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned      phase_start;
    int unsigned      r;
    logic [DistW-1:0] close_v;
    logic [DistW-1:0] open_v;
    logic [CountW-1:0] confirm_v;

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_CLOSE_DIST;
    cfg_data_i          <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.hand_tracked  <= 1'b0;
    in_ch.thumb_tracked <= 1'b0;
    in_ch.index_tracked <= 1'b0;
    in_ch.thumb_x       <= '0;
    in_ch.thumb_y       <= '0;
    in_ch.thumb_z       <= '0;
    in_ch.index_x       <= '0;
    in_ch.index_y       <= '0;
    in_ch.index_z       <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset thresholds (close 200^2, open 400^2,
    // confirm 3). Untracked frames right after reset must report the
    // cleared held distance and midpoint; each flag is dropped on its own.
    send_frame(noise_frame(3'b011));
    send_frame(noise_frame(3'b101));
    send_frame(noise_frame(3'b110));
    send_frame(noise_frame(3'b000));
    // Coinciding tips at the coordinate extremes: three in a row begin a pinch.
    repeat (3) send_frame(frame_of(3'b111, -32768, 32767, -32768, -32768, 32767, -32768));
    // Exactly at the open threshold: does not qualify.
    send_frame(frame_of(3'b111, 0, 0, 0, 400, 0, 0));
    // Largest possible separation, interrupted by a tracking dropout that
    // clears the run, then three in a row to release.
    repeat (2) send_frame(frame_of(3'b111, -32768, -32768, -32768, 32767, 32767, 32767));
    send_frame(noise_frame(3'b110));
    repeat (3) send_frame(frame_of(3'b111, -32768, -32768, -32768, 32767, 32767, 32767));
    // Exactly at the close threshold, then two frames just inside it with odd
    // sums of both signs to exercise the rounding of the midpoint.
    send_frame(frame_of(3'b111, 0, -100, 0, 0, 100, 0));
    send_frame(frame_of(3'b111, -3, 1, 7, 196, 20, 7));
    send_frame(frame_of(3'b111, -200, -1, -7, -1, 18, -7));
    // Confirm count lowered below the run in progress: the next qualifying
    // frame switches at once.
    drain();
    program_thresholds(CLOSE_DIST_RST, OPEN_DIST_RST, 8'd1, 1'b0);
    send_frame(frame_of(3'b111, 5, 5, 5, 5, 5, 5));
    // A confirm count of zero behaves as one.
    drain();
    program_thresholds(CLOSE_DIST_RST, OPEN_DIST_RST, 8'd0, 1'b1);
    send_frame(frame_of(3'b111, 32767, 32767, 32767, -32768, -32768, -32768));
    send_frame(frame_of(3'b111, 1, 2, 3, 1, 2, 3));

    // Random phases. The first uses the reset thresholds with confirm 0, the next
    // three pin them at extremes; the rest are random squares with a hysteresis band.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          close_v = CLOSE_DIST_RST; open_v = OPEN_DIST_RST; confirm_v = 8'd0;
        end
        1: begin
          close_v = '0; open_v = '0; confirm_v = 8'd1;
        end
        2: begin
          close_v = '1; open_v = '1; confirm_v = 8'd2;
        end
        3: begin
          close_v = DIST_TOP; open_v = DIST_TOP; confirm_v = 8'd255;
        end
        default: begin
          r         = $urandom_range(1, 3000);
          close_v   = DistW'(r * r);
          open_v    = close_v + DistW'($urandom_range(0, 4000000));
          confirm_v = CountW'($urandom_range(0, 6));
        end
      endcase
      drain();
      program_thresholds(close_v, open_v, confirm_v, $urandom_range(0, 1) != 0);
      phase_start = frames_sent;
      while (frames_sent - phase_start < PhaseItems) run_gesture();
    end

    // Let the last results through, then wait for anything the block
    // might still emit.
    drain();
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("pinch_gesture_qualifier_test: clean");
    end else begin
      $display("pinch_gesture_qualifier_test: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/pgq_pkg.sv
rtl/core/pgq_if.sv
rtl/core/pgq_front.sv
rtl/core/pgq_fifo.sv
rtl/core/pgq_back.sv
rtl/core/pinch_gesture_qualifier.sv
tb/pinch_gesture_qualifier_checker.sv
tb/pinch_gesture_qualifier_test.sv
